### design/ofsp_pkg.sv
// ofsp_pkg: shared character codes and state encodings for the face stream parser
// no dependencies; used by ofsp_parser

package ofsp_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_V     = 8'h76;
  localparam logic [7:0] CH_WS_LO = 8'h09;
  localparam logic [7:0] CH_WS_HI = 8'h0d;

  // what kind of row is open
  typedef enum logic [2:0] {
    KIND_OTHER = 3'b001,
    KIND_FACE  = 3'b010,
    KIND_SLASH = 3'b100
  } row_kind_t;

  // where the tokenizer stands inside one index token
  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_SIGN   = 4'b0010,
    PH_DIGITS = 4'b0100,
    PH_DONE   = 4'b1000
  } tok_phase_t;

endpackage

### design/ofsp_parser.sv
// ofsp_parser: row splitter, vertex counter and face index tokenizer
// one byte per strobe, result is combinational from the current byte and registered state; uses ofsp_pkg

module ofsp_parser #(
  parameter int MAX_ROW          = 512,
  parameter int MAX_FACE_INDICES = 32,
  parameter int INDEX_BITS       = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  byte_valid,
  input  logic [7:0]            byte_data,
  input  logic                  byte_last,
  output logic                  res_valid,
  output logic [INDEX_BITS-1:0] res_first,
  output logic [INDEX_BITS-1:0] res_prev,
  output logic [INDEX_BITS-1:0] res_this
);

  localparam int RL_W   = $clog2(MAX_ROW);
  localparam int IC_W   = $clog2(MAX_FACE_INDICES + 1);
  localparam int VC_W   = INDEX_BITS + 1;
  localparam int PROD_W = INDEX_BITS + 5;
  localparam logic [VC_W-1:0] VC_LIMIT = VC_W'(1) << INDEX_BITS;
  localparam logic [VC_W-1:0] MAG_CAP  = VC_LIMIT + VC_W'(1);
  localparam logic [RL_W-1:0] ROW_LAST = RL_W'(MAX_ROW - 2);
  localparam logic [IC_W-1:0] IC_MAX   = IC_W'(MAX_FACE_INDICES);

  logic [RL_W-1:0]       row_len_r, row_len_nxt;
  ofsp_pkg::row_kind_t   kind_r, kind_nxt;
  ofsp_pkg::tok_phase_t  phase_r, phase_nxt;
  logic                  vflag_r, vflag_nxt;
  logic                  neg_r, neg_nxt;
  logic [VC_W-1:0]       mag_r, mag_nxt;
  logic [IC_W-1:0]       icnt_r, icnt_nxt;
  logic                  first_ok_r, first_ok_nxt;
  logic [INDEX_BITS-1:0] first_idx_r, first_idx_nxt;
  logic                  prev_ok_r, prev_ok_nxt;
  logic [INDEX_BITS-1:0] prev_idx_r, prev_idx_nxt;
  logic [VC_W-1:0]       vcnt_r, vcnt_nxt;
  logic                  emit;
  logic [INDEX_BITS-1:0] code_idx;

  always_comb begin
    logic                  rs, blank, dropped, newline, store, ending, fin, do_fin;
    logic                  is_digit, code_ok;
    logic [3:0]            dval;
    logic [PROD_W-1:0]     prod;
    logic [VC_W-1:0]       idx_full;
    logic [IC_W-1:0]       icnt_inc;

    row_len_nxt   = row_len_r;
    kind_nxt      = kind_r;
    phase_nxt     = phase_r;
    vflag_nxt     = vflag_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    icnt_nxt      = icnt_r;
    first_ok_nxt  = first_ok_r;
    first_idx_nxt = first_idx_r;
    prev_ok_nxt   = prev_ok_r;
    prev_idx_nxt  = prev_idx_r;
    vcnt_nxt      = vcnt_r;
    emit          = 1'b0;
    code_idx      = '0;
    fin           = 1'b0;

    rs       = (row_len_r == '0);
    blank    = (byte_data == ofsp_pkg::CH_SPACE) || (byte_data == ofsp_pkg::CH_TAB);
    dropped  = (byte_data == ofsp_pkg::CH_BSL) || (byte_data == ofsp_pkg::CH_CR);
    newline  = (byte_data == ofsp_pkg::CH_LF);
    store    = !dropped && !newline && !(blank && rs);
    ending   = (newline && !rs) || (store && (row_len_r >= ROW_LAST));
    is_digit = (byte_data >= ofsp_pkg::CH_ZERO) && (byte_data <= ofsp_pkg::CH_NINE);
    dval     = 4'(byte_data - ofsp_pkg::CH_ZERO);
    prod     = (PROD_W'(mag_r) << 3) + (PROD_W'(mag_r) << 1) + PROD_W'(dval);

    // character step
    if (store) begin
      row_len_nxt = row_len_r + RL_W'(1);
      if (rs) begin
        if (byte_data == ofsp_pkg::CH_V) vflag_nxt = 1'b1;
        else if (byte_data == ofsp_pkg::CH_F) kind_nxt = ofsp_pkg::KIND_FACE;
      end else begin
        if ((row_len_r == RL_W'(1)) &&
            ((byte_data == ofsp_pkg::CH_N) || (byte_data == ofsp_pkg::CH_T))) begin
          vflag_nxt = 1'b0;
        end
        if (kind_r != ofsp_pkg::KIND_OTHER) begin
          if (byte_data == ofsp_pkg::CH_NUL) begin
            // text ends here; a pending token still completes
            fin      = (kind_r == ofsp_pkg::KIND_FACE) && (phase_r != ofsp_pkg::PH_IDLE);
            kind_nxt = ofsp_pkg::KIND_OTHER;
          end else if (blank) begin
            if (kind_r == ofsp_pkg::KIND_SLASH) kind_nxt = ofsp_pkg::KIND_FACE;
            else if (phase_r != ofsp_pkg::PH_IDLE) fin = 1'b1;
          end else if (kind_r == ofsp_pkg::KIND_FACE) begin
            case (phase_r)
              ofsp_pkg::PH_IDLE: begin
                if (byte_data == ofsp_pkg::CH_SLASH) begin
                  kind_nxt = ofsp_pkg::KIND_SLASH;
                end else begin
                  neg_nxt = 1'b0;
                  mag_nxt = '0;
                  if (byte_data inside {[ofsp_pkg::CH_WS_LO:ofsp_pkg::CH_WS_HI]}) begin
                    phase_nxt = ofsp_pkg::PH_SIGN;
                  end else if (byte_data == ofsp_pkg::CH_PLUS) begin
                    phase_nxt = ofsp_pkg::PH_DIGITS;
                  end else if (byte_data == ofsp_pkg::CH_MINUS) begin
                    neg_nxt   = 1'b1;
                    phase_nxt = ofsp_pkg::PH_DIGITS;
                  end else if (is_digit) begin
                    mag_nxt   = VC_W'(dval);
                    phase_nxt = ofsp_pkg::PH_DIGITS;
                  end else begin
                    phase_nxt = ofsp_pkg::PH_DONE;
                  end
                end
              end
              ofsp_pkg::PH_SIGN: begin
                if (byte_data inside {[ofsp_pkg::CH_WS_LO:ofsp_pkg::CH_WS_HI]}) begin
                  phase_nxt = ofsp_pkg::PH_SIGN;
                end else if (byte_data == ofsp_pkg::CH_PLUS) begin
                  phase_nxt = ofsp_pkg::PH_DIGITS;
                end else if (byte_data == ofsp_pkg::CH_MINUS) begin
                  neg_nxt   = 1'b1;
                  phase_nxt = ofsp_pkg::PH_DIGITS;
                end else if (is_digit) begin
                  mag_nxt   = VC_W'(dval);
                  phase_nxt = ofsp_pkg::PH_DIGITS;
                end else begin
                  phase_nxt = ofsp_pkg::PH_DONE;
                end
              end
              ofsp_pkg::PH_DIGITS: begin
                if (is_digit) begin
                  mag_nxt = (prod > PROD_W'(MAG_CAP)) ? MAG_CAP : VC_W'(prod);
                end else begin
                  phase_nxt = ofsp_pkg::PH_DONE;
                end
              end
              default: ;
            endcase
          end
        end
      end
    end

    // at most one index completes per byte: by its own char or by the row closing
    do_fin = fin || ((ending || byte_last) && (kind_nxt == ofsp_pkg::KIND_FACE) &&
                     (phase_nxt != ofsp_pkg::PH_IDLE));

    // in range exactly when 1 <= magnitude <= vertex count, for either sign
    code_ok  = (mag_nxt != '0) && (mag_nxt <= vcnt_r);
    idx_full = neg_nxt ? (vcnt_r - mag_nxt) : (mag_nxt - VC_W'(1));
    icnt_inc = icnt_r + IC_W'(1);

    if (do_fin) begin
      code_idx  = idx_full[INDEX_BITS-1:0];
      phase_nxt = ofsp_pkg::PH_IDLE;
      if (icnt_r == '0) begin
        first_ok_nxt  = code_ok;
        first_idx_nxt = code_idx;
      end else if (icnt_r >= IC_W'(2)) begin
        emit = first_ok_r && prev_ok_r && code_ok;
      end
      prev_ok_nxt  = code_ok;
      prev_idx_nxt = code_idx;
      icnt_nxt     = icnt_inc;
      if (icnt_inc >= IC_MAX) kind_nxt = ofsp_pkg::KIND_OTHER;
    end

    if (ending || byte_last) begin
      if (vflag_nxt && (vcnt_r < VC_LIMIT)) vcnt_nxt = vcnt_r + VC_W'(1);
      row_len_nxt  = '0;
      kind_nxt     = ofsp_pkg::KIND_OTHER;
      vflag_nxt    = 1'b0;
      phase_nxt    = ofsp_pkg::PH_IDLE;
      neg_nxt      = 1'b0;
      mag_nxt      = '0;
      icnt_nxt     = '0;
      first_ok_nxt = 1'b0;
      prev_ok_nxt  = 1'b0;
    end
    // a new stream is a new file
    if (byte_last) vcnt_nxt = '0;
  end

  assign res_valid = byte_valid && emit;
  assign res_first = first_idx_r;
  assign res_prev  = prev_idx_r;
  assign res_this  = code_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_len_r  <= '0;
      kind_r     <= ofsp_pkg::KIND_OTHER;
      phase_r    <= ofsp_pkg::PH_IDLE;
      vflag_r    <= 1'b0;
      neg_r      <= 1'b0;
      mag_r      <= '0;
      icnt_r     <= '0;
      first_ok_r <= 1'b0;
      prev_ok_r  <= 1'b0;
      vcnt_r     <= '0;
    end else if (byte_valid) begin
      row_len_r  <= row_len_nxt;
      kind_r     <= kind_nxt;
      phase_r    <= phase_nxt;
      vflag_r    <= vflag_nxt;
      neg_r      <= neg_nxt;
      mag_r      <= mag_nxt;
      icnt_r     <= icnt_nxt;
      first_ok_r <= first_ok_nxt;
      prev_ok_r  <= prev_ok_nxt;
      vcnt_r     <= vcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid) begin
      first_idx_r <= first_idx_nxt;
      prev_idx_r  <= prev_idx_nxt;
    end
  end

endmodule

### design/ofsp_out_buf.sv
// ofsp_out_buf: two-entry result buffer, output register plus skid entry
// no package dependencies

module ofsp_out_buf #(
  parameter int WIDTH = 72
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [WIDTH-1:0] out_tdata
);

  logic             main_vld_r, main_vld_nxt;
  logic             skid_vld_r, skid_vld_nxt;
  logic [WIDTH-1:0] main_data_r, main_data_nxt;
  logic [WIDTH-1:0] skid_data_r, skid_data_nxt;
  logic             pop;

  assign pop = main_vld_r && out_tready;

  // push never comes while the skid entry is occupied
  always_comb begin
    main_vld_nxt  = main_vld_r;
    skid_vld_nxt  = skid_vld_r;
    main_data_nxt = main_data_r;
    skid_data_nxt = skid_data_r;
    if (pop) begin
      if (skid_vld_r) begin
        main_data_nxt = skid_data_r;
        skid_vld_nxt  = 1'b0;
      end else if (push) begin
        main_data_nxt = push_data;
      end else begin
        main_vld_nxt = 1'b0;
      end
    end else if (push) begin
      if (main_vld_r) begin
        skid_vld_nxt  = 1'b1;
        skid_data_nxt = push_data;
      end else begin
        main_vld_nxt  = 1'b1;
        main_data_nxt = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_data_r <= main_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full       = skid_vld_r;
  assign out_tvalid = main_vld_r;
  assign out_tdata  = main_data_r;

endmodule

### design/obj_face_stream_parser.sv
// obj_face_stream_parser: top level of the text mesh face index parser
// instantiates ofsp_parser and ofsp_out_buf; uses ofsp_pkg through ofsp_parser

// Takes a text mesh file one byte per item (in_tlast on the final byte) and
// emits one fan triangle item (first, previous, this corner, zero based) for
// each face index from the third on whose three corners are all valid vertex
// indices. Vertex rows ("v" not followed by "n" or "t") are counted so that
// negative indices resolve against the count seen so far; the count restarts
// at zero after each final byte. Throughput is one byte per clock while the
// output buffer has room: each byte is held in the input register, and when it
// moves on, the character logic updates all row state and drops any triangle
// into a two-entry output buffer, whose output register drives out_tvalid.
// in_tready drops only while both output buffer entries hold untaken triangles.

module obj_face_stream_parser #(
  parameter int MAX_ROW          = 512,
  parameter int MAX_FACE_INDICES = 32,
  parameter int INDEX_BITS       = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // byte stream side
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] byte_in
  input  logic                   in_tlast,   // last_byte
  // triangle side
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // corner_first, corner_prev, corner_this from bit 0 up, zero padded to bytes
  output logic [((3*INDEX_BITS+7)/8)*8-1:0] out_tdata
);

  localparam int OUT_W   = ((3 * INDEX_BITS + 7) / 8) * 8;
  localparam int FIELD_W = 3 * INDEX_BITS;

  // input register
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       advance;
  logic       buf_full;

  // parser result
  logic                  res_valid;
  logic [INDEX_BITS-1:0] res_first;
  logic [INDEX_BITS-1:0] res_prev;
  logic [INDEX_BITS-1:0] res_this;
  logic [OUT_W-1:0]      res_packed;

  // the held byte moves on whenever the buffer has room for a possible triangle
  assign advance   = in_vld_r && !buf_full;
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  ofsp_parser #(
    .MAX_ROW          (MAX_ROW),
    .MAX_FACE_INDICES (MAX_FACE_INDICES),
    .INDEX_BITS       (INDEX_BITS)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (advance),
    .byte_data  (in_byte_r),
    .byte_last  (in_last_r),
    .res_valid  (res_valid),
    .res_first  (res_first),
    .res_prev   (res_prev),
    .res_this   (res_this)
  );

  // pad bits are zero; the pad is empty when the fields already fill whole bytes
  always_comb begin
    res_packed = '0;
    res_packed[FIELD_W-1:0] = {res_this, res_prev, res_first};
  end

  ofsp_out_buf #(
    .WIDTH (OUT_W)
  ) u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res_packed),
    .full       (buf_full),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### design/ofsp_checker.sv
// ofsp_checker: port level checks for obj_face_stream_parser
// bound to the top level at the end of this file; no package dependencies

module ofsp_checker #(
  parameter int TDATA_W = 72
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_tready,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [TDATA_W-1:0] out_tdata
);

  // a stalled triangle stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  // and keeps its corners
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out_tdata changed while stalled");

  // with an empty output buffer the input side never waits
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("in_tready low with no triangle pending");

  // reset empties the output buffer
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high right after reset");

endmodule

bind obj_face_stream_parser ofsp_checker #(
  .TDATA_W (OUT_W)
) u_ofsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
